### hdl/vbfa_pkg.sv
package vbfa_pkg;

   localparam int MAX_BLOCKS = 64;
   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int ADDR_W     = 16;
   localparam int LEN_W      = ADDR_W + 1;
   localparam int OWNER_W    = 8;
   localparam int SEG_W      = 2;
   localparam int MAX_SEGS   = 4;

   localparam logic [LEN_W-1:0] SPACE = LEN_W'(1) << ADDR_W;

   // actions
   localparam logic [1:0] ACT_ALLOC   = 2'd0;
   localparam logic [1:0] ACT_RELEASE = 2'd1;
   localparam logic [1:0] ACT_DEFRAG  = 2'd2;

   // policies
   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_FIT   = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR = 3'd3;
   localparam logic [2:0] ST_NOT_OWN  = 3'd4;
   localparam logic [2:0] ST_BAD_LEN  = 3'd5;

   // register indexes
   localparam logic [2:0] REG_POLICY    = 3'd0;
   localparam logic [2:0] REG_SEG_COUNT = 3'd1;
   localparam logic [2:0] REG_SEG1      = 3'd2;
   localparam logic [2:0] REG_SEG2      = 3'd3;
   localparam logic [2:0] REG_SEG3      = 3'd4;
   localparam logic [2:0] REG_MEM_END   = 3'd5;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [LEN_W-1:0]   len;
      logic [OWNER_W-1:0] owner;
      logic               used;
      logic [SEG_W-1:0]   seg;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]        policy;
      logic [2:0]        seg_count;
      logic [ADDR_W-1:0] seg1;
      logic [ADDR_W-1:0] seg2;
      logic [ADDR_W-1:0] seg3;
      logic [LEN_W-1:0]  mem_end;
      logic              csr_valid;
      logic              rebuild;
   } cfg_type;

endpackage

### hdl/vbfa_ifs.sv
interface vbfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    action;
   logic [vbfa_pkg::ADDR_W-1:0]   req_length;
   logic [vbfa_pkg::OWNER_W-1:0]  owner_id;
   logic [vbfa_pkg::ADDR_W-1:0]   area_start;
   modport source (output valid, action, req_length, owner_id, area_start, input ready);
   modport sink (input valid, action, req_length, owner_id, area_start, output ready);
endinterface

interface vbfa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [vbfa_pkg::ADDR_W-1:0] granted_address;
   modport source (output valid, status, granted_address, input ready);
   modport sink (input valid, status, granted_address, output ready);
endinterface

interface vbfa_csr_if;
   logic                       valid;
   logic                       ready;
   logic [2:0]                 index;
   logic [vbfa_pkg::LEN_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/variable_block_fit_allocator_core.sv
// channel    port       direction  fields
// request    req_chan   in         action, req_length, owner_id, area_start
// response   rsp_chan   out        status, granted_address
// registers  csr_chan   in         index, data
//
// one request at a time; allocate and release make one pipelined scan pass over the
// block memory for a table of n blocks; a split or merge then moves the entries that
// follow, and defragment reads each entry in turn and writes the used ones back packed,
// closing each segment with its free block. the block memory has one write and one
// registered read port. after reset and after a segment_count write the table is rebuilt.
// a stalled response holds in its register; a following request is still taken and its
// response waits behind it.
module variable_block_fit_allocator_core (
   input logic       clock,
   input logic       reset,
   vbfa_req_if.sink  req_chan,
   vbfa_rsp_if.source rsp_chan,
   vbfa_csr_if.sink  csr_chan
);

   logic [1:0]                   policy_ff;
   logic [2:0]                   segcnt_ff;
   logic [vbfa_pkg::ADDR_W-1:0]  seg1_ff, seg2_ff, seg3_ff;
   logic [vbfa_pkg::LEN_W-1:0]   mend_ff;
   logic                         idle;
   logic                         csr_xfer;
   vbfa_pkg::cfg_type            cfg;
   logic                         ram_we;
   logic [vbfa_pkg::IDX_W-1:0]   ram_waddr, ram_raddr;
   logic [vbfa_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

   assign csr_chan.ready = idle;
   assign csr_xfer = csr_chan.valid && idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= vbfa_pkg::POL_FIRST;
         segcnt_ff <= 3'd1;
         seg1_ff <= 16'd16384;
         seg2_ff <= 16'd32768;
         seg3_ff <= 16'd49152;
         mend_ff <= vbfa_pkg::SPACE;
      end else if (csr_xfer) begin
         case (csr_chan.index)
            vbfa_pkg::REG_POLICY:    policy_ff <= csr_chan.data[1:0];
            vbfa_pkg::REG_SEG_COUNT: segcnt_ff <= csr_chan.data[2:0];
            vbfa_pkg::REG_SEG1:      seg1_ff <= csr_chan.data[vbfa_pkg::ADDR_W-1:0];
            vbfa_pkg::REG_SEG2:      seg2_ff <= csr_chan.data[vbfa_pkg::ADDR_W-1:0];
            vbfa_pkg::REG_SEG3:      seg3_ff <= csr_chan.data[vbfa_pkg::ADDR_W-1:0];
            vbfa_pkg::REG_MEM_END:   mend_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.policy = policy_ff;
      cfg.seg_count = segcnt_ff;
      cfg.seg1 = seg1_ff;
      cfg.seg2 = seg2_ff;
      cfg.seg3 = seg3_ff;
      cfg.mem_end = mend_ff;
      cfg.csr_valid = csr_chan.valid;
      cfg.rebuild = csr_xfer && (csr_chan.index == vbfa_pkg::REG_SEG_COUNT);
   end

   vbfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .idle      (idle),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   vbfa_ram #(
      .DEPTH (vbfa_pkg::MAX_BLOCKS),
      .WIDTH (vbfa_pkg::ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

### hdl/vbfa_ram.sv
module vbfa_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### hdl/vbfa_ctrl.sv
module vbfa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  vbfa_pkg::cfg_type             cfg,
   output logic                          idle,
   vbfa_req_if.sink                      req,
   vbfa_rsp_if.source                    rsp,
   output logic                          ram_we,
   output logic [vbfa_pkg::IDX_W-1:0]    ram_waddr,
   output logic [vbfa_pkg::ENTRY_W-1:0]  ram_wdata,
   output logic [vbfa_pkg::IDX_W-1:0]    ram_raddr,
   input  logic [vbfa_pkg::ENTRY_W-1:0]  ram_rdata
);

   typedef enum logic [3:0] {
      S_REBUILD, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_W2,
      S_DF_RD, S_DF_PR, S_DF_PR2, S_RESP
   } state_type;

   localparam int CW = vbfa_pkg::CNT_W;
   localparam int IW = vbfa_pkg::IDX_W;
   localparam int LW = vbfa_pkg::LEN_W;
   localparam logic [CW-1:0] FULL = CW'(vbfa_pkg::MAX_BLOCKS);

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, pidx_ff, pidx_in;
   logic [CW-1:0] fidx_ff, fidx_in, moves_ff, moves_in, wp_ff, wp_in;
   logic dv_ff, dv_in, found_ff, found_in, done_ff, done_in;
   logic prev_v_ff, prev_v_in, next_v_ff, next_v_in, hprev_ff, hprev_in;
   logic [1:0] act_ff, act_in;
   logic [vbfa_pkg::ADDR_W-1:0] len_ff, len_in, area_ff, area_in, addr_ff, addr_in;
   logic [vbfa_pkg::OWNER_W-1:0] own_ff, own_in;
   vbfa_pkg::entry_type fe_ff, fe_in, pe_ff, pe_in, prev_ff, prev_in, next_ff, next_in;
   vbfa_pkg::entry_type cur_ff, cur_in, w2_d_ff, w2_d_in;
   logic [2:0] status_ff, status_in;
   logic w2_v_ff, w2_v_in, up_ff, up_in, pend_ff, pend_in;
   logic [1:0] k_ff, k_in;
   logic [IW-1:0] pdst_ff, pdst_in, w2_a_ff, w2_a_in;
   logic [vbfa_pkg::SEG_W-1:0] seg_ff, seg_in;
   logic [LW-1:0] cursor_ff, cursor_in, free_ff, free_in;
   logic first_ff, first_in;
   logic rsp_v_ff, rsp_v_in;
   logic [2:0] rsp_st_ff, rsp_st_in;
   logic [vbfa_pkg::ADDR_W-1:0] rsp_a_ff, rsp_a_in;

   vbfa_pkg::entry_type e, ne, de;
   logic [LW-1:0] req_len, tot, base;
   logic [2:0] nseg;
   logic [LW-1:0] mend;
   logic [LW-1:0] bnd [vbfa_pkg::MAX_SEGS+1];
   logic cand, mp, mn, chg;
   logic [1:0] kk;

   // segment bounds for the table rebuild
   always_comb begin
      nseg = cfg.seg_count;
      if (nseg == 3'd0) nseg = 3'd1;
      if (nseg > 3'(vbfa_pkg::MAX_SEGS)) nseg = 3'(vbfa_pkg::MAX_SEGS);
      mend = (cfg.mem_end > vbfa_pkg::SPACE) ? vbfa_pkg::SPACE : cfg.mem_end;
      bnd[0] = '0;
      bnd[1] = mend;
      bnd[2] = mend;
      bnd[3] = mend;
      bnd[4] = mend;
      if (nseg > 3'd1) begin
         bnd[1] = (LW'(cfg.seg1) > mend) ? mend : LW'(cfg.seg1);
      end
      if (nseg > 3'd2) begin
         bnd[2] = (LW'(cfg.seg2) < bnd[1]) ? bnd[1] : LW'(cfg.seg2);
         if (bnd[2] > mend) bnd[2] = mend;
      end
      if (nseg > 3'd3) begin
         bnd[3] = (LW'(cfg.seg3) < bnd[2]) ? bnd[2] : LW'(cfg.seg3);
         if (bnd[3] > mend) bnd[3] = mend;
      end
   end

   assign idle = (state_ff == S_IDLE);
   assign req.ready = (state_ff == S_IDLE) && !cfg.csr_valid;
   assign rsp.valid = rsp_v_ff;
   assign rsp.status = rsp_st_ff;
   assign rsp.granted_address = rsp_a_ff;
   assign req_len = LW'(len_ff);

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; pidx_in = pidx_ff;
      fidx_in = fidx_ff; moves_in = moves_ff; wp_in = wp_ff; dv_in = 1'b0;
      found_in = found_ff; done_in = done_ff; prev_v_in = prev_v_ff;
      next_v_in = next_v_ff; hprev_in = hprev_ff; act_in = act_ff; len_in = len_ff;
      area_in = area_ff; addr_in = addr_ff; own_in = own_ff; fe_in = fe_ff;
      pe_in = pe_ff; prev_in = prev_ff; next_in = next_ff; cur_in = cur_ff;
      w2_d_in = w2_d_ff; status_in = status_ff; w2_v_in = w2_v_ff; up_in = up_ff;
      pend_in = 1'b0; k_in = k_ff; pdst_in = pdst_ff; w2_a_in = w2_a_ff;
      seg_in = seg_ff; cursor_in = cursor_ff; free_in = free_ff; first_in = first_ff;
      rsp_v_in = rsp_v_ff; rsp_st_in = rsp_st_ff; rsp_a_in = rsp_a_ff;
      ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = idx_ff[IW-1:0];
      e = vbfa_pkg::entry_type'(ram_rdata);
      ne = '0; de = '0; tot = '0; base = '0; cand = 1'b0; mp = 1'b0; mn = 1'b0;
      chg = 1'b0; kk = 2'd1;

      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;

      case (state_ff)
         S_REBUILD: begin
            if (idx_ff == CW'(vbfa_pkg::MAX_SEGS)) begin
               state_in = S_IDLE;
            end else begin
               if (bnd[idx_ff[1:0] + 3'd1] > bnd[idx_ff[1:0]]) begin
                  ram_we = 1'b1;
                  ram_waddr = count_ff[IW-1:0];
                  ne.start = bnd[idx_ff[1:0]][vbfa_pkg::ADDR_W-1:0];
                  ne.len = bnd[idx_ff[1:0] + 3'd1] - bnd[idx_ff[1:0]];
                  ne.seg = idx_ff[1:0];
                  ram_wdata = ne;
                  count_in = count_ff + CW'(1);
               end
               idx_in = idx_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (cfg.rebuild) begin
               state_in = S_REBUILD;
               idx_in = '0;
               count_in = '0;
            end else if (req.valid && req.ready) begin
               act_in = req.action; len_in = req.req_length; own_in = req.owner_id;
               area_in = req.area_start; addr_in = '0; status_in = vbfa_pkg::ST_OK;
               idx_in = '0; found_in = 1'b0; done_in = 1'b0; prev_v_in = 1'b0;
               next_v_in = 1'b0; hprev_in = 1'b0; w2_v_in = 1'b0; moves_in = '0;
               wp_in = '0; first_in = 1'b1; free_in = '0;
               case (req.action)
                  vbfa_pkg::ACT_ALLOC: begin
                     if (req.req_length == '0) begin
                        status_in = vbfa_pkg::ST_BAD_LEN;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  vbfa_pkg::ACT_RELEASE: state_in = S_SCAN;
                  vbfa_pkg::ACT_DEFRAG: state_in = S_DF_RD;
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (idx_ff < count_ff) begin
               dv_in = 1'b1;
               pidx_in = idx_ff;
               idx_in = idx_ff + CW'(1);
            end else if (!dv_ff) begin
               state_in = S_DECIDE;
            end
            if (dv_ff) begin
               if (act_ff == vbfa_pkg::ACT_ALLOC) begin
                  cand = !e.used && (e.len >= req_len) && !done_ff;
                  if (cand) begin
                     case (cfg.policy)
                        vbfa_pkg::POL_BEST: begin
                           if (e.len == req_len) begin
                              done_in = 1'b1; found_in = 1'b1; fe_in = e; fidx_in = pidx_ff;
                           end else if (!found_ff || e.len < fe_ff.len) begin
                              found_in = 1'b1; fe_in = e; fidx_in = pidx_ff;
                           end
                        end
                        vbfa_pkg::POL_WORST: begin
                           if (!found_ff || e.len > fe_ff.len) begin
                              found_in = 1'b1; fe_in = e; fidx_in = pidx_ff;
                           end
                        end
                        default: begin
                           done_in = 1'b1; found_in = 1'b1; fe_in = e; fidx_in = pidx_ff;
                        end
                     endcase
                  end
               end else begin
                  if (!found_ff && e.start == area_ff) begin
                     found_in = 1'b1; fe_in = e; fidx_in = pidx_ff;
                     hprev_in = prev_v_ff; pe_in = prev_ff;
                  end else if (!found_ff) begin
                     prev_v_in = 1'b1; prev_in = e;
                  end else if (!next_v_ff && pidx_ff == fidx_ff + CW'(1)) begin
                     next_v_in = 1'b1; next_in = e;
                  end
               end
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (act_ff == vbfa_pkg::ACT_ALLOC) begin
               if (!found_ff) begin
                  status_in = vbfa_pkg::ST_NO_FIT;
               end else if (fe_ff.len == req_len) begin
                  ne = fe_ff; ne.used = 1'b1; ne.owner = own_ff;
                  ram_we = 1'b1; ram_waddr = fidx_ff[IW-1:0]; ram_wdata = ne;
                  addr_in = fe_ff.start;
               end else if (count_ff == FULL) begin
                  status_in = vbfa_pkg::ST_FULL;
               end else begin
                  tot = fe_ff.len - req_len;
                  de = fe_ff; de.len = tot;
                  ram_we = 1'b1; ram_waddr = fidx_ff[IW-1:0]; ram_wdata = de;
                  ne = fe_ff; ne.start = fe_ff.start + tot[vbfa_pkg::ADDR_W-1:0];
                  ne.len = req_len; ne.owner = own_ff; ne.used = 1'b1;
                  addr_in = ne.start;
                  w2_v_in = 1'b1; w2_d_in = ne; w2_a_in = fidx_ff[IW-1:0] + IW'(1);
                  up_in = 1'b1; idx_in = count_ff - CW'(1);
                  moves_in = count_ff - fidx_ff - CW'(1);
                  count_in = count_ff + CW'(1);
                  state_in = S_SHIFT;
               end
            end else begin
               mp = hprev_ff && !pe_ff.used && pe_ff.seg == fe_ff.seg;
               mn = next_v_ff && !next_ff.used && next_ff.seg == fe_ff.seg;
               if (!found_ff) begin
                  status_in = vbfa_pkg::ST_BAD_ADDR;
               end else if (!fe_ff.used || fe_ff.owner != own_ff) begin
                  status_in = vbfa_pkg::ST_NOT_OWN;
               end else if (len_ff == '0 || req_len > fe_ff.len) begin
                  status_in = vbfa_pkg::ST_BAD_LEN;
               end else if (req_len < fe_ff.len) begin
                  ne = fe_ff; ne.start = fe_ff.start + len_ff;
                  ne.len = fe_ff.len - req_len;
                  if (count_ff == FULL) begin
                     status_in = vbfa_pkg::ST_FULL;
                  end else if (mp) begin
                     de = pe_ff; de.len = pe_ff.len + req_len;
                     ram_we = 1'b1; ram_waddr = fidx_ff[IW-1:0] - IW'(1); ram_wdata = de;
                     w2_v_in = 1'b1; w2_d_in = ne; w2_a_in = fidx_ff[IW-1:0];
                     state_in = S_W2;
                  end else begin
                     de = fe_ff; de.len = req_len; de.used = 1'b0; de.owner = '0;
                     ram_we = 1'b1; ram_waddr = fidx_ff[IW-1:0]; ram_wdata = de;
                     w2_v_in = 1'b1; w2_d_in = ne; w2_a_in = fidx_ff[IW-1:0] + IW'(1);
                     up_in = 1'b1; idx_in = count_ff - CW'(1);
                     moves_in = count_ff - fidx_ff - CW'(1);
                     count_in = count_ff + CW'(1);
                     state_in = S_SHIFT;
                  end
               end else begin
                  tot = fe_ff.len + (mn ? next_ff.len : '0);
                  if (mp) begin
                     kk = mn ? 2'd2 : 2'd1;
                     de = pe_ff; de.len = pe_ff.len + tot;
                     ram_we = 1'b1; ram_waddr = fidx_ff[IW-1:0] - IW'(1); ram_wdata = de;
                     up_in = 1'b0; k_in = kk; idx_in = fidx_ff + CW'(kk);
                     moves_in = count_ff - fidx_ff - CW'(kk);
                     count_in = count_ff - CW'(kk);
                     state_in = S_SHIFT;
                  end else begin
                     de = fe_ff; de.len = tot; de.used = 1'b0; de.owner = '0;
                     ram_we = 1'b1; ram_waddr = fidx_ff[IW-1:0]; ram_wdata = de;
                     if (mn) begin
                        up_in = 1'b0; k_in = 2'd1; idx_in = fidx_ff + CW'(2);
                        moves_in = count_ff - fidx_ff - CW'(2);
                        count_in = count_ff - CW'(1);
                        state_in = S_SHIFT;
                     end
                  end
               end
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               ram_we = 1'b1; ram_waddr = pdst_ff; ram_wdata = ram_rdata;
            end
            if (moves_ff != '0) begin
               pend_in = 1'b1;
               pdst_in = up_ff ? idx_ff[IW-1:0] + IW'(1) : idx_ff[IW-1:0] - IW'(k_ff);
               idx_in = up_ff ? idx_ff - CW'(1) : idx_ff + CW'(1);
               moves_in = moves_ff - CW'(1);
            end else if (!pend_ff) begin
               state_in = w2_v_ff ? S_W2 : S_RESP;
            end
         end
         S_W2: begin
            ram_we = 1'b1; ram_waddr = w2_a_ff; ram_wdata = w2_d_ff;
            state_in = S_RESP;
         end
         S_DF_RD: begin
            if (idx_ff == count_ff) begin
               if (!first_ff && free_ff != '0) begin
                  ne.start = cursor_ff[vbfa_pkg::ADDR_W-1:0]; ne.len = free_ff; ne.seg = seg_ff;
                  ram_we = 1'b1; ram_waddr = wp_ff[IW-1:0]; ram_wdata = ne;
                  count_in = wp_ff + CW'(1);
               end else begin
                  count_in = wp_ff;
               end
               state_in = S_RESP;
            end else begin
               state_in = S_DF_PR;
            end
         end
         S_DF_PR, S_DF_PR2: begin
            if (state_ff == S_DF_PR2) e = cur_ff;
            cur_in = e;
            chg = !first_ff && e.seg != seg_ff;
            if (chg && free_ff != '0) begin
               // close the previous segment with its free block
               ne.start = cursor_ff[vbfa_pkg::ADDR_W-1:0]; ne.len = free_ff; ne.seg = seg_ff;
               ram_we = 1'b1; ram_waddr = wp_ff[IW-1:0]; ram_wdata = ne;
               wp_in = wp_ff + CW'(1);
               free_in = '0;
               state_in = S_DF_PR2;
            end else begin
               base = (first_ff || chg) ? LW'(e.start) : cursor_ff;
               first_in = 1'b0;
               seg_in = e.seg;
               if (e.used) begin
                  de = e; de.start = base[vbfa_pkg::ADDR_W-1:0];
                  ram_we = 1'b1; ram_waddr = wp_ff[IW-1:0]; ram_wdata = de;
                  wp_in = wp_ff + CW'(1);
                  cursor_in = base + e.len;
               end else begin
                  cursor_in = base;
                  free_in = free_ff + e.len;
               end
               idx_in = idx_ff + CW'(1);
               state_in = S_DF_RD;
            end
         end
         S_RESP: begin
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1; rsp_st_in = status_ff; rsp_a_in = addr_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_REBUILD;
         count_ff <= '0;
         idx_ff <= '0;
         dv_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff <= idx_in;
         dv_ff <= dv_in;
         pend_ff <= pend_in;
         rsp_v_ff <= rsp_v_in;
      end
      pidx_ff <= pidx_in; fidx_ff <= fidx_in; moves_ff <= moves_in; wp_ff <= wp_in;
      found_ff <= found_in; done_ff <= done_in; prev_v_ff <= prev_v_in;
      next_v_ff <= next_v_in; hprev_ff <= hprev_in; act_ff <= act_in; len_ff <= len_in;
      area_ff <= area_in; addr_ff <= addr_in; own_ff <= own_in; fe_ff <= fe_in;
      pe_ff <= pe_in; prev_ff <= prev_in; next_ff <= next_in; cur_ff <= cur_in;
      w2_d_ff <= w2_d_in; status_ff <= status_in; w2_v_ff <= w2_v_in; up_ff <= up_in;
      k_ff <= k_in; pdst_ff <= pdst_in; w2_a_ff <= w2_a_in; seg_ff <= seg_in;
      cursor_ff <= cursor_in; free_ff <= free_in; first_ff <= first_in;
      rsp_st_ff <= rsp_st_in; rsp_a_ff <= rsp_a_in;
   end

endmodule

### dv/vbfa_alloc_tb_pkg.sv
package vbfa_alloc_tb_pkg;
   import vbfa_pkg::*;

   typedef struct {
      logic [ADDR_W-1:0]  start;
      logic [LEN_W-1:0]   len;
      logic [OWNER_W-1:0] owner;
      logic               used;
      logic [SEG_W-1:0]   seg;
   } blk_rec;

   typedef struct {
      logic [2:0]        status;
      logic [ADDR_W-1:0] addr;
   } grant_rec;

   class alloc_scoreboard;
      logic [1:0]        policy;
      logic [2:0]        seg_count;
      logic [ADDR_W-1:0] seg_start [1:3];
      logic [16:0]       mem_end;
      blk_rec            blocks [$];
      grant_rec          pending [$];
      int                errors;
      int                checked;
      int                ok_allocs;
      int                ok_releases;
      int                defrags;

      function new();
         policy = POL_FIRST;
         seg_count = 3'd1;
         seg_start[1] = 16'd16384;
         seg_start[2] = 16'd32768;
         seg_start[3] = 16'd49152;
         mem_end = 17'h10000;
         errors = 0;
         checked = 0;
         ok_allocs = 0;
         ok_releases = 0;
         defrags = 0;
         rebuild_table();
      endfunction

      function void rebuild_table();
         longint bound [0:4];
         longint lim;
         longint s;
         int n;
         blk_rec b;
         n = seg_count;
         if (n < 1) n = 1;
         if (n > MAX_SEGS) n = MAX_SEGS;
         lim = mem_end;
         if (lim > 65536) lim = 65536;
         bound[0] = 0;
         for (int i = 1; i < n; i++) begin
            s = seg_start[i];
            if (s < bound[i-1]) s = bound[i-1];
            if (s > lim) s = lim;
            bound[i] = s;
         end
         bound[n] = lim;
         blocks.delete();
         for (int i = 0; i < n; i++) begin
            if (bound[i+1] > bound[i] && blocks.size() < MAX_BLOCKS) begin
               b.start = ADDR_W'(bound[i]);
               b.len = LEN_W'(bound[i+1] - bound[i]);
               b.owner = '0;
               b.used = 1'b0;
               b.seg = SEG_W'(i);
               blocks.push_back(b);
            end
         end
      endfunction

      function void write_reg(logic [2:0] idx, logic [16:0] data);
         case (idx)
            REG_POLICY: policy = data[1:0];
            REG_SEG_COUNT: begin
               seg_count = data[2:0];
               rebuild_table();
            end
            REG_SEG1: seg_start[1] = data[15:0];
            REG_SEG2: seg_start[2] = data[15:0];
            REG_SEG3: seg_start[3] = data[15:0];
            REG_MEM_END: mem_end = data;
            default: ;
         endcase
      endfunction

      function grant_rec allocate(logic [LEN_W-1:0] len, logic [OWNER_W-1:0] owner);
         grant_rec r;
         int pick;
         blk_rec nb;
         r.status = ST_OK;
         r.addr = '0;
         pick = -1;
         if (len == 0) begin
            r.status = ST_BAD_LEN;
            return r;
         end
         foreach (blocks[i]) begin
            if (blocks[i].used || blocks[i].len < len) continue;
            if (policy == POL_BEST) begin
               if (blocks[i].len == len) begin
                  pick = i;
                  break;
               end
               if (pick < 0 || blocks[i].len < blocks[pick].len) pick = i;
            end else if (policy == POL_WORST) begin
               if (pick < 0 || blocks[i].len > blocks[pick].len) pick = i;
            end else begin
               pick = i;
               break;
            end
         end
         if (pick < 0) begin
            r.status = ST_NO_FIT;
            return r;
         end
         if (blocks[pick].len == len) begin
            blocks[pick].used = 1'b1;
            blocks[pick].owner = owner;
            r.addr = blocks[pick].start;
            return r;
         end
         if (blocks.size() >= MAX_BLOCKS) begin
            r.status = ST_FULL;
            return r;
         end
         // carve from the top of the chosen free block
         nb.len = len;
         nb.start = ADDR_W'(LEN_W'(blocks[pick].start) + (blocks[pick].len - len));
         nb.owner = owner;
         nb.used = 1'b1;
         nb.seg = blocks[pick].seg;
         blocks[pick].len = blocks[pick].len - len;
         blocks.insert(pick + 1, nb);
         r.addr = nb.start;
         return r;
      endfunction

      function logic [2:0] release_area(logic [ADDR_W-1:0] start, logic [LEN_W-1:0] len,
                                        logic [OWNER_W-1:0] owner);
         int i;
         blk_rec nb;
         i = -1;
         foreach (blocks[k]) begin
            if (blocks[k].start == start) begin
               i = k;
               break;
            end
         end
         if (i < 0) return ST_BAD_ADDR;
         if (!blocks[i].used || blocks[i].owner != owner) return ST_NOT_OWN;
         if (len == 0 || len > blocks[i].len) return ST_BAD_LEN;
         if (len < blocks[i].len) begin
            if (blocks.size() >= MAX_BLOCKS) return ST_FULL;
            nb = blocks[i];
            nb.start = ADDR_W'(LEN_W'(blocks[i].start) + len);
            nb.len = blocks[i].len - len;
            blocks[i].len = len;
            blocks[i].used = 1'b0;
            blocks[i].owner = '0;
            blocks.insert(i + 1, nb);
         end else begin
            blocks[i].used = 1'b0;
            blocks[i].owner = '0;
            if (i + 1 < blocks.size() && !blocks[i+1].used
                && blocks[i+1].seg == blocks[i].seg) begin
               blocks[i].len = blocks[i].len + blocks[i+1].len;
               blocks.delete(i + 1);
            end
         end
         if (i > 0 && !blocks[i-1].used && blocks[i-1].seg == blocks[i].seg) begin
            blocks[i-1].len = blocks[i-1].len + blocks[i].len;
            blocks.delete(i);
         end
         return ST_OK;
      endfunction

      function void compact();
         blk_rec packed_q [$];
         blk_rec cur;
         int r;
         logic [SEG_W-1:0] seg;
         longint cursor;
         longint free_total;
         r = 0;
         while (r < blocks.size()) begin
            seg = blocks[r].seg;
            cursor = blocks[r].start;
            free_total = 0;
            while (r < blocks.size() && blocks[r].seg == seg) begin
               cur = blocks[r];
               if (cur.used) begin
                  cur.start = ADDR_W'(cursor);
                  cursor += cur.len;
                  packed_q.push_back(cur);
               end else begin
                  free_total += cur.len;
               end
               r++;
            end
            if (free_total != 0) begin
               cur.start = ADDR_W'(cursor);
               cur.len = LEN_W'(free_total);
               cur.owner = '0;
               cur.used = 1'b0;
               cur.seg = seg;
               packed_q.push_back(cur);
            end
         end
         blocks = packed_q;
      endfunction

      function void note_request(logic [1:0] action, logic [ADDR_W-1:0] len,
                                 logic [OWNER_W-1:0] owner, logic [ADDR_W-1:0] start);
         grant_rec r;
         r.status = ST_OK;
         r.addr = '0;
         if (action == ACT_ALLOC) begin
            r = allocate(LEN_W'(len), owner);
            if (r.status == ST_OK) ok_allocs++;
         end else if (action == ACT_RELEASE) begin
            r.status = release_area(start, LEN_W'(len), owner);
            if (r.status == ST_OK) ok_releases++;
         end else if (action == ACT_DEFRAG) begin
            compact();
            defrags++;
         end
         pending.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_grant(logic [2:0] status, logic [ADDR_W-1:0] addr);
         grant_rec e;
         checked++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response status %0d addr %0h", status, addr));
            return;
         end
         e = pending.pop_front();
         if (status !== e.status)
            report($sformatf("status got %0d want %0d", status, e.status));
         if (addr !== e.addr)
            report($sformatf("granted_address got %0h want %0h", addr, e.addr));
      endtask

      // owned blocks, for building sensible release requests
      function int owned_count();
         int n;
         n = 0;
         foreach (blocks[i]) if (blocks[i].used) n++;
         return n;
      endfunction

      function blk_rec owned_pick(int k);
         foreach (blocks[i]) begin
            if (blocks[i].used) begin
               if (k == 0) return blocks[i];
               k--;
            end
         end
         return blocks[0];
      endfunction
   endclass
endpackage

### dv/variable_block_fit_allocator_core_tb.sv
module variable_block_fit_allocator_core_tb;
   import vbfa_pkg::*;
   import vbfa_alloc_tb_pkg::*;

   logic clock;
   logic reset;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   mismatches;

   vbfa_req_if req_chan ();
   vbfa_rsp_if rsp_chan ();
   vbfa_csr_if csr_chan ();

   alloc_scoreboard ledger;

   variable_block_fit_allocator_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3000000) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // receiver side: random stall, check every response transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            ledger.check_grant(rsp_chan.status, rsp_chan.granted_address);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_request(logic [1:0] action, logic [15:0] len,
                               logic [7:0] owner, logic [15:0] start);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_chan.valid <= 1'b1;
      req_chan.action <= action;
      req_chan.req_length <= len;
      req_chan.owner_id <= owner;
      req_chan.area_start <= start;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ledger.note_request(action, len, owner, start);
      // drop valid so the next transfer is driven on a later edge
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (ledger.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [16:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= data;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      ledger.write_reg(idx, data);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_layout(logic [2:0] nseg, logic [15:0] s1, logic [15:0] s2,
                             logic [15:0] s3, logic [16:0] mend);
      write_reg(REG_SEG1, {1'b0, s1});
      write_reg(REG_SEG2, {1'b0, s2});
      write_reg(REG_SEG3, {1'b0, s3});
      write_reg(REG_MEM_END, mend);
      write_reg(REG_SEG_COUNT, {14'd0, nseg});
      repeat (20) @(posedge clock);
   endtask

   task automatic random_request();
      int roll;
      blk_rec b;
      logic [15:0] len;
      roll = $urandom_range(99);
      if (roll < 50) begin
         // mostly small lengths, a few large or odd ones
         if ($urandom_range(9) < 8) len = 16'($urandom_range(1, 600));
         else len = 16'($urandom);
         send_request(ACT_ALLOC, len, 8'($urandom), 16'($urandom));
      end else if (roll < 85 && ledger.owned_count() > 0) begin
         b = ledger.owned_pick($urandom_range(ledger.owned_count() - 1));
         len = ($urandom_range(3) == 0) ? 16'($urandom_range(1, b.len)) : b.len[15:0];
         if ($urandom_range(19) == 0) len = 16'(b.len + 1);
         if ($urandom_range(29) == 0)
            send_request(ACT_RELEASE, len, b.owner ^ 8'h01, b.start);
         else
            send_request(ACT_RELEASE, len, b.owner, b.start);
      end else if (roll < 92) begin
         send_request(ACT_DEFRAG, 16'($urandom), 8'($urandom), 16'($urandom));
      end else begin
         send_request(2'($urandom_range(3)), 16'($urandom_range(0, 65535)),
                      8'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      ledger = new();
      reset = 1'b1;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_chan.valid = 1'b0;
      req_chan.action = ACT_ALLOC;
      req_chan.req_length = '0;
      req_chan.owner_id = '0;
      req_chan.area_start = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = REG_POLICY;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (20) @(posedge clock);

      // directed: default layout, first fit
      send_request(ACT_ALLOC, 16'd0, 8'd1, 16'd0);
      send_request(ACT_ALLOC, 16'hffff, 8'hff, 16'd0);
      send_request(ACT_ALLOC, 16'd100, 8'd1, 16'd0);
      send_request(ACT_ALLOC, 16'd1, 8'd2, 16'd0);
      send_request(ACT_RELEASE, 16'd10, 8'd1, 16'd65436);
      send_request(ACT_RELEASE, 16'd10, 8'd2, 16'd65436);
      send_request(ACT_RELEASE, 16'd0, 8'd1, 16'd65436);
      send_request(ACT_RELEASE, 16'd200, 8'd1, 16'd65436);
      send_request(ACT_RELEASE, 16'd40, 8'd1, 16'd65436);
      send_request(ACT_RELEASE, 16'd5, 8'd0, 16'd1);
      send_request(ACT_RELEASE, 16'd5, 8'd0, 16'hffff);
      send_request(2'd3, 16'hffff, 8'hff, 16'hffff);
      send_request(ACT_DEFRAG, 16'd0, 8'd0, 16'd0);
      send_request(ACT_RELEASE, 16'd1, 8'd2, 16'hffff);
      drain();

      // four segments; exercise best/worst/unused policy and a full table
      set_layout(3'd4, 16'd100, 16'd300, 16'd600, 17'd1000);
      write_reg(REG_POLICY, {15'd0, POL_BEST});
      send_request(ACT_ALLOC, 16'd200, 8'd3, 16'd0);
      send_request(ACT_ALLOC, 16'd50, 8'd3, 16'd0);
      write_reg(REG_POLICY, {15'd0, POL_WORST});
      send_request(ACT_ALLOC, 16'd400, 8'd4, 16'd0);
      send_request(ACT_ALLOC, 16'd20, 8'd4, 16'd0);
      write_reg(REG_POLICY, 17'd3);
      send_request(ACT_ALLOC, 16'd10, 8'd5, 16'd0);
      for (int i = 0; i < 70; i++) send_request(ACT_ALLOC, 16'd1, 8'd6, 16'd0);
      send_request(ACT_DEFRAG, 16'd0, 8'd0, 16'd0);
      drain();

      // random phases across layouts, policies and idling styles
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         drain();
         write_reg(REG_POLICY, {15'd0, 2'(ph % 4)});
         case (ph)
            0: set_layout(3'd0, 16'd0, 16'd0, 16'd0, 17'h1ffff);
            1: set_layout(3'd7, 16'd2000, 16'd1000, 16'd4000, 17'd6000);
            2: set_layout(3'd2, 16'hffff, 16'd0, 16'd0, 17'd3000);
            3: set_layout(3'd4, 16'd0, 16'd500, 16'd500, 17'd1500);
            4: set_layout(3'd3, 16'd1024, 16'd2048, 16'd0, 17'd1);
            5: set_layout(3'd4, 16'd1200, 16'd2400, 16'd3600, 17'd4800);
            6: set_layout(3'd1, 16'd0, 16'd0, 16'd0, 17'h10000);
            default: set_layout(3'd4, 16'($urandom), 16'($urandom), 16'($urandom),
                                17'($urandom_range(1, 65536)));
         endcase
         for (int i = 0; i < 76; i++) random_request();
      end

      drain();
      $display("checked %0d responses: %0d grants, %0d releases, %0d defragments",
               ledger.checked, ledger.ok_allocs, ledger.ok_releases, ledger.defrags);
      $display("covered all policies, layouts of one to four segments, and idle/stall mixes");
      mismatches = ledger.errors;
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
